// File: rtl/arcball_orientation_tracker_unit_assert.svh
// ----------------------------------------------------------------------------
// Arcball tracker assertion macros
// Shared concurrent checks, reset-qualified on rst_n.
// ----------------------------------------------------------------------------
`ifndef ARCBALL_ORIENTATION_TRACKER_UNIT_ASSERT_SVH
`define ARCBALL_ORIENTATION_TRACKER_UNIT_ASSERT_SVH

// same-cycle implication
`define AOTU_CHECK_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("check failed");

// next-cycle implication
`define AOTU_CHECK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("check failed");

`endif

// File: rtl/aotu_pkg.sv
// ----------------------------------------------------------------------------
// Arcball tracker package
// Shared types, codes and constants.
// ----------------------------------------------------------------------------
package aotu_pkg;

  localparam int DU_W = 40;

  localparam logic [1:0] ACT_BEGIN   = 2'd0;
  localparam logic [1:0] ACT_DRAG    = 2'd1;
  localparam logic [1:0] ACT_RELEASE = 2'd2;

  typedef logic signed [17:0] fx_t;

  typedef struct packed {
    logic            start;
    logic            is_sqrt;
    logic [DU_W-1:0] num;
    logic [DU_W-1:0] den;
  } du_req_t;

  typedef enum logic [3:0] {
    S_IDLE, S_NX, S_NY, S_R2, S_SQ, S_PX, S_PY, S_CHK,
    S_CROSS, S_ZCHK, S_N2, S_NSQ, S_QD, S_QM, S_DONE
  } seq_state_t;

endpackage

// File: rtl/aotu_divsqrt.sv
// ----------------------------------------------------------------------------
// Arcball tracker divide / square-root unit
// Restoring divide, one quotient bit a cycle; integer square root, one
// result bit a cycle. done pulses for one cycle with res valid.
// ----------------------------------------------------------------------------
module aotu_divsqrt (
  input  logic                      clk,
  input  logic                      rst_n,
  input  aotu_pkg::du_req_t         req,
  output logic                      done,
  output logic [aotu_pkg::DU_W-1:0] res
);

  localparam int W = aotu_pkg::DU_W;

  logic         busy_r, done_r, sq_r;
  logic [5:0]   cnt_r;
  logic [W-1:0] q_r, v_r, r_r, bit_r;
  logic [W:0]   rem_r, trial;
  logic [W-1:0] sum;
  logic [5:0]   last;

  assign trial = {rem_r[W-1:0], q_r[W-1]};
  assign sum   = r_r + bit_r;
  assign last  = sq_r ? 6'd19 : 6'd39;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == last) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      sq_r  <= req.is_sqrt;
      q_r   <= req.num;
      rem_r <= '0;
      v_r   <= req.num;
      r_r   <= '0;
      bit_r <= {2'b01, {(W-2){1'b0}}};
    end else if (busy_r) begin
      if (sq_r) begin
        if (v_r >= sum) begin
          v_r <= v_r - sum;
          r_r <= (r_r >> 1) + bit_r;
        end else begin
          r_r <= r_r >> 1;
        end
        bit_r <= bit_r >> 2;
      end else begin
        if (trial >= {1'b0, req.den}) begin
          rem_r <= trial - {1'b0, req.den};
          q_r   <= {q_r[W-2:0], 1'b1};
        end else begin
          rem_r <= trial;
          q_r   <= {q_r[W-2:0], 1'b0};
        end
      end
    end
  end

  assign done = done_r;
  assign res  = sq_r ? r_r : q_r;

  `include "arcball_orientation_tracker_unit_assert.svh"

  `AOTU_CHECK_NEXT(a_done_after_busy, busy_r && cnt_r == last && !req.start, done_r)
  `AOTU_CHECK_NOW(a_done_idle, done_r, !busy_r)
  `AOTU_CHECK_NOW(a_cnt_bound, busy_r, cnt_r <= last)

endmodule

// File: rtl/arcball_orientation_tracker_unit.sv
// ----------------------------------------------------------------------------
// Arcball orientation tracker unit
// Release and ignored events go straight to the result; a begin or a drag is
// worked through the shared divide/square-root unit before its result loads.
// Throughput: one event at a time; the next is taken after the result loads.
// Reset: synchronous; identity orientation, not rotating, 640 x 480 window.
// ----------------------------------------------------------------------------
module arcball_orientation_tracker_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_action,
  input  logic [11:0]        in_mouse_x,
  input  logic [11:0]        in_mouse_y,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_quat_w,
  output logic signed [15:0] out_quat_x,
  output logic signed [15:0] out_quat_y,
  output logic signed [15:0] out_quat_z,
  output logic               out_rotating,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int W = aotu_pkg::DU_W;
  localparam aotu_pkg::fx_t ONE = 18'sd16384;

  function automatic aotu_pkg::fx_t clamp1(input logic signed [W-1:0] v);
    if (v > 40'sd16384) return ONE;
    else if (v < -40'sd16384) return -ONE;
    else return v[17:0];
  endfunction

  function automatic logic signed [W-1:0] rnd14(input logic signed [W-1:0] v);
    logic [W-1:0] m;
    m = v[W-1] ? -v : v;
    m = (m + 40'd8192) >> 14;
    return v[W-1] ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic [W-1:0] scaled(input aotu_pkg::fx_t v, input logic [17:0] d);
    logic [17:0] m;
    m = v[17] ? 18'(-v) : 18'(v);
    return ({22'd0, m} << 14) + {23'd0, d[17:1]};
  endfunction

  function automatic aotu_pkg::fx_t apply_sgn(input logic neg, input logic [W-1:0] m);
    logic signed [W-1:0] s;
    s = neg ? -$signed(m) : $signed(m);
    return clamp1(s);
  endfunction

  aotu_pkg::seq_state_t state_r, state_nxt;
  logic [12:0]   win_w_r, win_h_r, w_eff, h_eff;
  aotu_pkg::fx_t sp_r [3], sp_nxt [3];
  aotu_pkg::fx_t cp_r [3], cp_nxt [3];
  aotu_pkg::fx_t so_r [4], so_nxt [4];
  aotu_pkg::fx_t co_r [4], co_nxt [4];
  aotu_pkg::fx_t cr_r [4], cr_nxt [4];
  aotu_pkg::fx_t qv_r [4], qv_nxt [4];
  logic          drag_r, drag_nxt, go_r, go_nxt;
  logic [1:0]    act_r, act_nxt, j_r, j_nxt, t_r, t_nxt;
  logic [11:0]   mx_r, mx_nxt, my_r, my_nxt;
  aotu_pkg::fx_t px_r, px_nxt, py_r, py_nxt, w0_r, w0_nxt;
  logic [17:0]   rr_r, rr_nxt, nn_r, nn_nxt;
  logic signed [W-1:0] acc_r, acc_nxt, sum, rnd;
  aotu_pkg::fx_t opa, opb;
  logic          neg;
  logic signed [35:0] prod, term;
  aotu_pkg::du_req_t du_req;
  logic          du_done;
  logic [W-1:0]  du_res;
  logic          in_acc, in_disk, last_t;
  logic          ov_r;
  logic signed [15:0] oq_r [4];
  logic          orot_r;

  aotu_divsqrt u_du (.clk(clk), .rst_n(rst_n), .req(du_req), .done(du_done), .res(du_res));

  assign w_eff  = (win_w_r == 13'd0) ? 13'd1 : win_w_r;
  assign h_eff  = (win_h_r == 13'd0) ? 13'd1 : win_h_r;
  assign in_acc = in_valid && !in_stall;
  assign in_stall = (state_r != aotu_pkg::S_IDLE);
  assign in_disk = (acc_r < 40'sd67108864);

  always_comb begin
    opa = '0;
    opb = '0;
    neg = 1'b0;
    case (state_r)
      aotu_pkg::S_R2: begin
        opa = t_r[0] ? py_r : px_r;
        opb = opa;
      end
      aotu_pkg::S_CROSS: begin
        case (j_r)
          2'd0: begin
            opa = t_r[0] ? sp_r[2] : sp_r[1];
            opb = t_r[0] ? cp_r[1] : cp_r[2];
          end
          2'd1: begin
            opa = t_r[0] ? sp_r[0] : sp_r[2];
            opb = t_r[0] ? cp_r[2] : cp_r[0];
          end
          2'd2: begin
            opa = t_r[0] ? sp_r[1] : sp_r[0];
            opb = t_r[0] ? cp_r[0] : cp_r[1];
          end
          default: begin
            opa = (t_r == 2'd3) ? '0 : sp_r[t_r];
            opb = (t_r == 2'd3) ? '0 : cp_r[t_r];
          end
        endcase
        if (j_r != 2'd3) begin
          neg = t_r[0];
          if (t_r == 2'd2) opa = '0;
        end
      end
      aotu_pkg::S_N2: begin
        opa = (t_r == 2'd0) ? w0_r : cr_r[t_r - 2'd1];
        opb = opa;
      end
      aotu_pkg::S_QM: begin
        opa = qv_r[t_r];
        opb = so_r[t_r ^ j_r];
        case (j_r)
          2'd0:    neg = (t_r != 2'd0);
          2'd1:    neg = (t_r == 2'd3);
          2'd2:    neg = (t_r == 2'd1);
          default: neg = (t_r == 2'd2);
        endcase
      end
      default: ;
    endcase
  end

  assign prod = opa * opb;
  assign term = neg ? -prod : prod;
  assign sum  = ((t_r == 2'd0) ? 40'sd0 : acc_r) + {{4{term[35]}}, term};
  assign rnd  = rnd14(sum);

  always_comb begin
    last_t = 1'b0;
    case (state_r)
      aotu_pkg::S_R2:    last_t = (t_r == 2'd1);
      aotu_pkg::S_CROSS: last_t = (t_r == 2'd2);
      default:           last_t = (t_r == 2'd3);
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      aotu_pkg::S_IDLE:
        if (in_acc) begin
          if (in_action == aotu_pkg::ACT_BEGIN ||
              (in_action == aotu_pkg::ACT_DRAG && drag_r)) state_nxt = aotu_pkg::S_NX;
          else state_nxt = aotu_pkg::S_DONE;
        end
      aotu_pkg::S_NX:  if (go_r && du_done) state_nxt = aotu_pkg::S_NY;
      aotu_pkg::S_NY:  if (go_r && du_done) state_nxt = aotu_pkg::S_R2;
      aotu_pkg::S_R2:  if (last_t) state_nxt = aotu_pkg::S_SQ;
      aotu_pkg::S_SQ:
        if (go_r && du_done) state_nxt = in_disk ? aotu_pkg::S_CHK : aotu_pkg::S_PX;
      aotu_pkg::S_PX:  if (go_r && du_done) state_nxt = aotu_pkg::S_PY;
      aotu_pkg::S_PY:  if (go_r && du_done) state_nxt = aotu_pkg::S_CHK;
      aotu_pkg::S_CHK:
        state_nxt = (act_r == aotu_pkg::ACT_BEGIN) ? aotu_pkg::S_DONE : aotu_pkg::S_CROSS;
      aotu_pkg::S_CROSS: if (last_t && j_r == 2'd3) state_nxt = aotu_pkg::S_ZCHK;
      aotu_pkg::S_ZCHK:
        if (cr_r[0] == '0 && cr_r[1] == '0 && cr_r[2] == '0) state_nxt = aotu_pkg::S_QM;
        else state_nxt = aotu_pkg::S_N2;
      aotu_pkg::S_N2:  if (last_t) state_nxt = aotu_pkg::S_NSQ;
      aotu_pkg::S_NSQ: if (go_r && du_done) state_nxt = aotu_pkg::S_QD;
      aotu_pkg::S_QD:  if (go_r && du_done && j_r == 2'd3) state_nxt = aotu_pkg::S_QM;
      aotu_pkg::S_QM:  if (last_t && j_r == 2'd3) state_nxt = aotu_pkg::S_DONE;
      aotu_pkg::S_DONE: if (!ov_r || !out_stall) state_nxt = aotu_pkg::S_IDLE;
      default: state_nxt = aotu_pkg::S_IDLE;
    endcase
  end

  // datapath and unit requests
  always_comb begin
    sp_nxt = sp_r; cp_nxt = cp_r; so_nxt = so_r; co_nxt = co_r;
    cr_nxt = cr_r; qv_nxt = qv_r;
    drag_nxt = drag_r; go_nxt = go_r; act_nxt = act_r;
    j_nxt = j_r; t_nxt = t_r; mx_nxt = mx_r; my_nxt = my_r;
    px_nxt = px_r; py_nxt = py_r; w0_nxt = w0_r; rr_nxt = rr_r; nn_nxt = nn_r;
    acc_nxt = acc_r;
    du_req = '0;
    case (state_r)
      aotu_pkg::S_IDLE:
        if (in_acc) begin
          act_nxt = in_action;
          mx_nxt  = in_mouse_x;
          my_nxt  = in_mouse_y;
        end
      aotu_pkg::S_NX: begin
        du_req.num = {14'd0, mx_r, 14'd0} + {28'd0, w_eff[12:1]};
        du_req.den = {27'd0, w_eff};
        du_req.start = !go_r;
        go_nxt = 1'b1;
        if (go_r && du_done) begin
          px_nxt = clamp1($signed(du_res) - 40'sd8192);
          go_nxt = 1'b0;
        end
      end
      aotu_pkg::S_NY: begin
        du_req.num = {14'd0, my_r, 14'd0} + {28'd0, h_eff[12:1]};
        du_req.den = {27'd0, h_eff};
        du_req.start = !go_r;
        go_nxt = 1'b1;
        if (go_r && du_done) begin
          py_nxt = clamp1(40'sd8192 - $signed(du_res));
          go_nxt = 1'b0;
        end
      end
      aotu_pkg::S_R2: begin
        acc_nxt = sum;
        t_nxt = last_t ? 2'd0 : t_r + 2'd1;
      end
      aotu_pkg::S_SQ: begin
        du_req.is_sqrt = 1'b1;
        du_req.num = in_disk ? (40'd268435456 - ($unsigned(acc_r) << 2)) : $unsigned(acc_r);
        du_req.start = !go_r;
        go_nxt = 1'b1;
        if (go_r && du_done) begin
          go_nxt = 1'b0;
          if (in_disk) begin
            cp_nxt[0] = px_r <<< 1;
            cp_nxt[1] = py_r <<< 1;
            cp_nxt[2] = du_res[17:0];
          end else begin
            rr_nxt = du_res[17:0];
          end
        end
      end
      aotu_pkg::S_PX: begin
        du_req.num = scaled(px_r, rr_r);
        du_req.den = {22'd0, rr_r};
        du_req.start = !go_r;
        go_nxt = 1'b1;
        if (go_r && du_done) begin
          cp_nxt[0] = apply_sgn(px_r[17], du_res);
          go_nxt = 1'b0;
        end
      end
      aotu_pkg::S_PY: begin
        du_req.num = scaled(py_r, rr_r);
        du_req.den = {22'd0, rr_r};
        du_req.start = !go_r;
        go_nxt = 1'b1;
        if (go_r && du_done) begin
          cp_nxt[1] = apply_sgn(py_r[17], du_res);
          cp_nxt[2] = '0;
          go_nxt = 1'b0;
        end
      end
      aotu_pkg::S_CHK:
        if (act_r == aotu_pkg::ACT_BEGIN) begin
          sp_nxt = cp_r;
          so_nxt = co_r;
          drag_nxt = 1'b1;
        end
      aotu_pkg::S_CROSS: begin
        acc_nxt = sum;
        t_nxt = last_t ? 2'd0 : t_r + 2'd1;
        if (last_t) begin
          cr_nxt[j_r] = (j_r == 2'd3) ? clamp1(rnd) : rnd[17:0];
          j_nxt = j_r + 2'd1;
        end
      end
      aotu_pkg::S_ZCHK:
        if (cr_r[0] == '0 && cr_r[1] == '0 && cr_r[2] == '0) begin
          qv_nxt[0] = ONE; qv_nxt[1] = '0; qv_nxt[2] = '0; qv_nxt[3] = '0;
        end else begin
          w0_nxt = ONE + cr_r[3];
        end
      aotu_pkg::S_N2: begin
        acc_nxt = sum;
        t_nxt = t_r + 2'd1;
      end
      aotu_pkg::S_NSQ: begin
        du_req.is_sqrt = 1'b1;
        du_req.num = $unsigned(acc_r);
        du_req.start = !go_r;
        go_nxt = 1'b1;
        if (go_r && du_done) begin
          nn_nxt = (du_res == '0) ? 18'd1 : du_res[17:0];
          go_nxt = 1'b0;
        end
      end
      aotu_pkg::S_QD: begin
        du_req.num = scaled((j_r == 2'd0) ? w0_r : cr_r[j_r - 2'd1], nn_r);
        du_req.den = {22'd0, nn_r};
        du_req.start = !go_r;
        go_nxt = 1'b1;
        if (go_r && du_done) begin
          qv_nxt[j_r] = apply_sgn(((j_r == 2'd0) ? w0_r[17] : cr_r[j_r - 2'd1][17]), du_res);
          j_nxt = j_r + 2'd1;
          go_nxt = 1'b0;
        end
      end
      aotu_pkg::S_QM: begin
        acc_nxt = sum;
        t_nxt = t_r + 2'd1;
        if (last_t) begin
          co_nxt[j_r] = clamp1(rnd);
          j_nxt = j_r + 2'd1;
        end
      end
      aotu_pkg::S_DONE:
        if ((!ov_r || !out_stall) && act_r == aotu_pkg::ACT_RELEASE) drag_nxt = 1'b0;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= aotu_pkg::S_IDLE;
      win_w_r <= 13'd640;
      win_h_r <= 13'd480;
      drag_r  <= 1'b0;
      go_r    <= 1'b0;
      j_r     <= '0;
      t_r     <= '0;
      ov_r    <= 1'b0;
      for (int i = 0; i < 3; i++) sp_r[i] <= '0;
      for (int i = 0; i < 4; i++) begin
        so_r[i] <= (i == 0) ? ONE : '0;
        co_r[i] <= (i == 0) ? ONE : '0;
      end
    end else begin
      state_r <= state_nxt;
      drag_r  <= drag_nxt;
      go_r    <= go_nxt;
      j_r     <= j_nxt;
      t_r     <= t_nxt;
      sp_r    <= sp_nxt;
      so_r    <= so_nxt;
      co_r    <= co_nxt;
      if (psel && penable && pwrite) begin
        if (paddr[2]) win_h_r <= pwdata[12:0];
        else          win_w_r <= pwdata[12:0];
      end
      if (state_r == aotu_pkg::S_DONE && (!ov_r || !out_stall)) ov_r <= 1'b1;
      else if (!out_stall) ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    act_r <= act_nxt;
    mx_r  <= mx_nxt;
    my_r  <= my_nxt;
    px_r  <= px_nxt;
    py_r  <= py_nxt;
    w0_r  <= w0_nxt;
    rr_r  <= rr_nxt;
    nn_r  <= nn_nxt;
    acc_r <= acc_nxt;
    cp_r  <= cp_nxt;
    cr_r  <= cr_nxt;
    qv_r  <= qv_nxt;
    if (state_r == aotu_pkg::S_DONE && (!ov_r || !out_stall)) begin
      for (int i = 0; i < 4; i++) oq_r[i] <= co_r[i][15:0];
      orot_r <= drag_nxt;
    end
  end

  assign out_valid    = ov_r;
  assign out_quat_w   = oq_r[0];
  assign out_quat_x   = oq_r[1];
  assign out_quat_y   = oq_r[2];
  assign out_quat_z   = oq_r[3];
  assign out_rotating = orot_r;
  assign pready       = 1'b1;
  assign prdata       = paddr[2] ? {19'd0, win_h_r} : {19'd0, win_w_r};

  `include "arcball_orientation_tracker_unit_assert.svh"

  `AOTU_CHECK_NEXT(a_busy_after_accept, in_acc, in_stall)
  `AOTU_CHECK_NOW(a_orient_range, 1'b1, co_r[0] <= ONE && co_r[0] >= -ONE)
  `AOTU_CHECK_NEXT(a_hold_done, state_r == aotu_pkg::S_DONE && ov_r && out_stall,
                   state_r == aotu_pkg::S_DONE)
  `AOTU_CHECK_NOW(a_no_start_idle, du_req.start, state_r != aotu_pkg::S_IDLE)

endmodule
